// ===== design/pst_pkg.sv =====
// shared types and constants for the point-in-shapes tester
// used by the core and its port checker; depends on nothing

package pst_pkg;

    localparam int MAX_FIGURES_DEF = 16;
    localparam int COORD_BITS_DEF  = 24;

    localparam int ACTION_W  = 2;
    localparam int KIND_W    = 2;
    localparam int RADIUS_W  = 23;
    localparam int POINT_W   = 16;
    localparam int FIG_NUM_W = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_APPEND = 2'd1,
        ACT_QUERY  = 2'd2
    } action_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_RECT   = 2'd0,
        KIND_CIRCLE = 2'd1,
        KIND_TRI    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_NEXT,
        ST_DONE
    } state_t;

    // operand sources of the shared subtract-multiply unit
    localparam int NSRC = 10;

    typedef enum logic [3:0] {
        SRC_ZERO = 4'd0,
        SRC_X0   = 4'd1,
        SRC_Y0   = 4'd2,
        SRC_X1   = 4'd3,
        SRC_Y1   = 4'd4,
        SRC_X2   = 4'd5,
        SRC_Y2   = 4'd6,
        SRC_PX   = 4'd7,
        SRC_PY   = 4'd8,
        SRC_R    = 4'd9
    } src_t;

    typedef struct packed {
        src_t a1;
        src_t a2;
        src_t b1;
        src_t b2;
    } op_sel_t;

endpackage

// ===== design/pst_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module pst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== design/point_in_shapes_tester_core.sv =====
// point-in-shapes tester: figure table in ram, one shared subtract-multiply unit
// depends on pst_pkg and pst_ram
//
// usage
//   input channel item_valid/item_ready carries one item: action, shape_kind,
//   ax..cy and radius. clear and append leave the core idle; an append to a
//   full table is dropped. a query latches ax/ay as the point and walks the
//   table in order, testing one figure at a time; item_ready stays low until
//   the final result of the query has been placed in the output register.
//   output channel result_valid/result_ready carries one result per containing
//   figure, in table order, or a single result with contained low when no
//   figure holds the point; last marks the final result of each query.
//   each stored figure is tested through the subtract, multiply and accumulate
//   stages of the one multiplier: a circle needs three products, a triangle
//   eight; a rectangle is compared directly and an unused kind never hits.
//   a hit is held back one figure so that last can be set on it; if the
//   receiver stalls, the walk waits on the next hit or at the end of the table
//   until the output register frees up.
//   reset empties the table and sets the point number to one; the ram itself
//   is not cleared, as only appended entries are ever read.

module point_in_shapes_tester_core #(
    parameter int MAX_FIGURES = pst_pkg::MAX_FIGURES_DEF,
    parameter int COORD_BITS  = pst_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    output logic                              item_ready,
    input  logic [pst_pkg::ACTION_W-1:0]      action,
    input  logic [pst_pkg::KIND_W-1:0]        shape_kind,
    input  logic signed [COORD_BITS-1:0]      ax,
    input  logic signed [COORD_BITS-1:0]      ay,
    input  logic signed [COORD_BITS-1:0]      bx,
    input  logic signed [COORD_BITS-1:0]      by,
    input  logic signed [COORD_BITS-1:0]      cx,
    input  logic signed [COORD_BITS-1:0]      cy,
    input  logic [pst_pkg::RADIUS_W-1:0]      radius,
    output logic                              result_valid,
    input  logic                              result_ready,
    output logic [pst_pkg::POINT_W-1:0]       point_number,
    output logic [pst_pkg::FIG_NUM_W-1:0]     figure_number,
    output logic                              contained,
    output logic                              last
);

    import pst_pkg::*;

    localparam int IDX_W  = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
    localparam int CNT_W  = $clog2(MAX_FIGURES + 1);
    localparam int FIG_W  = KIND_W + 6 * COORD_BITS + RADIUS_W;
    localparam int OP_W   = (COORD_BITS > RADIUS_W) ? COORD_BITS + 1 : RADIUS_W + 1;
    localparam int PROD_W = 2 * OP_W;
    localparam int ACC_W  = PROD_W + 3;
    localparam int STEP_W = 4;

    localparam int R_LSB    = 0;
    localparam int Y2_LSB   = R_LSB + RADIUS_W;
    localparam int X2_LSB   = Y2_LSB + COORD_BITS;
    localparam int Y1_LSB   = X2_LSB + COORD_BITS;
    localparam int X1_LSB   = Y1_LSB + COORD_BITS;
    localparam int Y0_LSB   = X1_LSB + COORD_BITS;
    localparam int X0_LSB   = Y0_LSB + COORD_BITS;
    localparam int KIND_LSB = X0_LSB + COORD_BITS;

    // step at which each kind has its verdict
    localparam logic [STEP_W-1:0] STEP_RECT_DONE = STEP_W'(0);
    localparam logic [STEP_W-1:0] STEP_CIRC_DONE = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_TRI_DONE  = STEP_W'(11);
    // triangle: first area pair lands in area_reg, last pair lands
    localparam logic [STEP_W-1:0] STEP_TRI_WHOLE = STEP_W'(4);
    localparam logic [STEP_W-1:0] STEP_TRI_LAST  = STEP_W'(10);

    state_t                       state_reg, state_next;
    logic [CNT_W-1:0]             fig_count_reg, fig_count_next;
    logic [POINT_W-1:0]           query_count_reg, query_count_next;
    logic [IDX_W-1:0]             fig_idx_reg, fig_idx_next;
    logic [STEP_W-1:0]            step_reg, step_next;
    logic                         hit_reg, hit_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [FIG_NUM_W-1:0]         pend_fig_reg, pend_fig_next;
    logic                         out_valid_reg, out_valid_next;
    logic [POINT_W-1:0]           out_point_reg, out_point_next;
    logic [FIG_NUM_W-1:0]         out_fig_reg, out_fig_next;
    logic                         out_contained_reg, out_contained_next;
    logic                         out_last_reg, out_last_next;
    logic signed [COORD_BITS-1:0] px_reg, px_next;
    logic signed [COORD_BITS-1:0] py_reg, py_next;

    logic signed [OP_W-1:0]       dd_a_reg, dd_a_next;
    logic signed [OP_W-1:0]       dd_b_reg, dd_b_next;
    logic signed [PROD_W-1:0]     prod_reg, prod_next;
    logic signed [ACC_W-1:0]      acc_reg, acc_next;
    logic signed [ACC_W-1:0]      area_reg, area_next;
    logic signed [ACC_W-1:0]      sum_reg, sum_next;
    logic                         zf_reg, zf_next;

    logic                         ram_wr_en;
    logic                         ram_rd_en;
    logic [IDX_W-1:0]             ram_rd_addr;
    logic [FIG_W-1:0]             ram_wr_data;
    logic [FIG_W-1:0]             rd_data;

    logic [KIND_W-1:0]            fig_kind;
    logic signed [COORD_BITS-1:0] x0, y0, x1, y1, x2, y2;
    logic [RADIUS_W-1:0]          fig_rad;
    logic [NSRC*OP_W-1:0]         src_bus;
    op_sel_t                      op_sel;
    logic signed [ACC_W-1:0]      prod_ext;
    logic                         hit_now;
    logic [STEP_W-1:0]            done_step;
    logic                         out_free;
    logic [CNT_W-1:0]             fig_nxt_cnt;

    function automatic logic signed [OP_W-1:0] pick(input src_t s,
                                                    input logic [NSRC*OP_W-1:0] bus);
        pick = signed'(bus[s*OP_W +: OP_W]);
    endfunction

    function automatic logic [OP_W-1:0] sext(input logic [COORD_BITS-1:0] v);
        sext = {{(OP_W - COORD_BITS){v[COORD_BITS-1]}}, v};
    endfunction

    assign ram_wr_data = {shape_kind, ax, ay, bx, by, cx, cy, radius};

    pst_ram #(
        .WIDTH (FIG_W),
        .DEPTH (MAX_FIGURES)
    ) u_fig_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (fig_count_reg[IDX_W-1:0]),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (rd_data)
    );

    assign fig_kind = rd_data[KIND_LSB +: KIND_W];
    assign x0       = rd_data[X0_LSB +: COORD_BITS];
    assign y0       = rd_data[Y0_LSB +: COORD_BITS];
    assign x1       = rd_data[X1_LSB +: COORD_BITS];
    assign y1       = rd_data[Y1_LSB +: COORD_BITS];
    assign x2       = rd_data[X2_LSB +: COORD_BITS];
    assign y2       = rd_data[Y2_LSB +: COORD_BITS];
    assign fig_rad  = rd_data[R_LSB +: RADIUS_W];

    // ordered as src_t, zero at the bottom
    assign src_bus = {{{(OP_W - RADIUS_W){1'b0}}, fig_rad},
                      sext(py_reg), sext(px_reg),
                      sext(y2), sext(x2), sext(y1), sext(x1), sext(y0), sext(x0),
                      {OP_W{1'b0}}};

    // operand schedule: op k issues at step k
    always_comb
    begin
        op_sel = '{SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO};
        case (fig_kind)
            KIND_CIRCLE:
            begin
                case (step_reg)
                    STEP_W'(0): op_sel = '{SRC_PX, SRC_X0, SRC_PX, SRC_X0};
                    STEP_W'(1): op_sel = '{SRC_PY, SRC_Y0, SRC_PY, SRC_Y0};
                    STEP_W'(2): op_sel = '{SRC_R, SRC_ZERO, SRC_R, SRC_ZERO};
                    default:    op_sel = '{SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO};
                endcase
            end
            KIND_TRI:
            begin
                case (step_reg)
                    // whole area
                    STEP_W'(0): op_sel = '{SRC_X1, SRC_X0, SRC_Y2, SRC_Y0};
                    STEP_W'(1): op_sel = '{SRC_X2, SRC_X0, SRC_Y1, SRC_Y0};
                    // point, v1, v2
                    STEP_W'(2): op_sel = '{SRC_X1, SRC_PX, SRC_Y2, SRC_PY};
                    STEP_W'(3): op_sel = '{SRC_X2, SRC_PX, SRC_Y1, SRC_PY};
                    // v0, point, v2
                    STEP_W'(4): op_sel = '{SRC_PX, SRC_X0, SRC_Y2, SRC_Y0};
                    STEP_W'(5): op_sel = '{SRC_X2, SRC_X0, SRC_PY, SRC_Y0};
                    // v0, v1, point
                    STEP_W'(6): op_sel = '{SRC_X1, SRC_X0, SRC_PY, SRC_Y0};
                    STEP_W'(7): op_sel = '{SRC_PX, SRC_X0, SRC_Y1, SRC_Y0};
                    default:    op_sel = '{SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO};
                endcase
            end
            default:
            begin
                op_sel = '{SRC_ZERO, SRC_ZERO, SRC_ZERO, SRC_ZERO};
            end
        endcase
    end

    assign dd_a_next = pick(op_sel.a1, src_bus) - pick(op_sel.a2, src_bus);
    assign dd_b_next = pick(op_sel.b1, src_bus) - pick(op_sel.b2, src_bus);
    assign prod_next = dd_a_reg * dd_b_reg;
    assign prod_ext  = {{(ACC_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // accumulate stage: product of op k is in prod_reg at step k+2
    always_comb
    begin
        acc_next  = acc_reg;
        area_next = area_reg;
        sum_next  = sum_reg;
        zf_next   = zf_reg;
        if (state_reg == ST_EXEC)
        begin
            case (fig_kind)
                KIND_CIRCLE:
                begin
                    if (step_reg == STEP_W'(2))
                    begin
                        acc_next = prod_ext;
                    end
                    else if (step_reg == STEP_W'(3))
                    begin
                        acc_next = acc_reg + prod_ext;
                    end
                end
                KIND_TRI:
                begin
                    if (step_reg >= STEP_W'(2) && step_reg <= STEP_W'(9))
                    begin
                        if (!step_reg[0])
                        begin
                            acc_next = prod_ext;
                        end
                        else
                        begin
                            area_next = acc_reg - prod_ext;
                        end
                    end
                    // sum of sub-area magnitudes minus whole-area magnitude
                    if (step_reg == STEP_TRI_WHOLE)
                    begin
                        sum_next = area_reg[ACC_W-1] ? area_reg : -area_reg;
                        zf_next  = 1'b0;
                    end
                    else if (step_reg > STEP_TRI_WHOLE && step_reg <= STEP_TRI_LAST
                             && !step_reg[0])
                    begin
                        sum_next = area_reg[ACC_W-1] ? sum_reg - area_reg
                                                     : sum_reg + area_reg;
                        zf_next  = zf_reg | (area_reg == '0);
                    end
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (fig_kind)
            KIND_RECT:
            begin
                hit_now   = (px_reg > x0) && (px_reg < x1) && (py_reg < y0) && (py_reg > y1);
                done_step = STEP_RECT_DONE;
            end
            KIND_CIRCLE:
            begin
                hit_now   = acc_reg < prod_ext;
                done_step = STEP_CIRC_DONE;
            end
            KIND_TRI:
            begin
                hit_now   = !zf_reg && (sum_reg == '0);
                done_step = STEP_TRI_DONE;
            end
            default:
            begin
                hit_now   = 1'b0;
                done_step = STEP_RECT_DONE;
            end
        endcase
    end

    assign out_free    = !out_valid_reg || result_ready;
    assign fig_nxt_cnt = CNT_W'(fig_idx_reg) + CNT_W'(1);

    always_comb
    begin
        state_next         = state_reg;
        fig_count_next     = fig_count_reg;
        query_count_next   = query_count_reg;
        fig_idx_next       = fig_idx_reg;
        step_next          = step_reg;
        hit_next           = hit_reg;
        pend_valid_next    = pend_valid_reg;
        pend_fig_next      = pend_fig_reg;
        out_valid_next     = out_valid_reg && !result_ready;
        out_point_next     = out_point_reg;
        out_fig_next       = out_fig_reg;
        out_contained_next = out_contained_reg;
        out_last_next      = out_last_reg;
        px_next            = px_reg;
        py_next            = py_reg;
        ram_wr_en          = 1'b0;
        ram_rd_en          = 1'b0;
        ram_rd_addr        = fig_idx_reg;
        item_ready         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    case (action)
                        ACT_CLEAR:
                        begin
                            fig_count_next   = '0;
                            query_count_next = POINT_W'(1);
                        end
                        ACT_APPEND:
                        begin
                            if (fig_count_reg < CNT_W'(MAX_FIGURES))
                            begin
                                ram_wr_en      = 1'b1;
                                fig_count_next = fig_count_reg + CNT_W'(1);
                            end
                        end
                        ACT_QUERY:
                        begin
                            px_next         = ax;
                            py_next         = ay;
                            pend_valid_next = 1'b0;
                            fig_idx_next    = '0;
                            step_next       = '0;
                            if (fig_count_reg != '0)
                            begin
                                ram_rd_en   = 1'b1;
                                ram_rd_addr = '0;
                                state_next  = ST_EXEC;
                            end
                            else
                            begin
                                state_next = ST_DONE;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_EXEC:
            begin
                step_next = step_reg + STEP_W'(1);
                if (step_reg == done_step)
                begin
                    hit_next   = hit_now;
                    state_next = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                // a held hit can only be released into a free output register
                if (!(hit_reg && pend_valid_reg && !out_free))
                begin
                    if (hit_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next     = 1'b1;
                            out_point_next     = query_count_reg;
                            out_fig_next       = pend_fig_reg;
                            out_contained_next = 1'b1;
                            out_last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_fig_next   = FIG_NUM_W'(fig_nxt_cnt);
                    end
                    if (fig_nxt_cnt < fig_count_reg)
                    begin
                        fig_idx_next = fig_nxt_cnt[IDX_W-1:0];
                        ram_rd_en    = 1'b1;
                        ram_rd_addr  = fig_nxt_cnt[IDX_W-1:0];
                        step_next    = '0;
                        state_next   = ST_EXEC;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_point_next     = query_count_reg;
                    out_fig_next       = pend_valid_reg ? pend_fig_reg : '0;
                    out_contained_next = pend_valid_reg;
                    out_last_next      = 1'b1;
                    query_count_next   = query_count_reg + POINT_W'(1);
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fig_count_reg   <= '0;
            query_count_reg <= POINT_W'(1);
            fig_idx_reg     <= '0;
            step_reg        <= '0;
            hit_reg         <= 1'b0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            fig_count_reg   <= fig_count_next;
            query_count_reg <= query_count_next;
            fig_idx_reg     <= fig_idx_next;
            step_reg        <= step_next;
            hit_reg         <= hit_next;
            pend_valid_reg  <= pend_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_fig_reg      <= pend_fig_next;
        out_point_reg     <= out_point_next;
        out_fig_reg       <= out_fig_next;
        out_contained_reg <= out_contained_next;
        out_last_reg      <= out_last_next;
        px_reg            <= px_next;
        py_reg            <= py_next;
        dd_a_reg          <= dd_a_next;
        dd_b_reg          <= dd_b_next;
        prod_reg          <= prod_next;
        acc_reg           <= acc_next;
        area_reg          <= area_next;
        sum_reg           <= sum_next;
        zf_reg            <= zf_next;
    end

    assign result_valid  = out_valid_reg;
    assign point_number  = out_point_reg;
    assign figure_number = out_fig_reg;
    assign contained     = out_contained_reg;
    assign last          = out_last_reg;

endmodule

// ===== design/pst_checker.sv =====
// port-level checks for the point-in-shapes tester, bound to the core
// depends on pst_pkg and point_in_shapes_tester_core

module pst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic [pst_pkg::ACTION_W-1:0]  action,
    input logic                          result_valid,
    input logic                          result_ready,
    input logic [pst_pkg::POINT_W-1:0]   point_number,
    input logic [pst_pkg::FIG_NUM_W-1:0] figure_number,
    input logic                          contained,
    input logic                          last
);

    import pst_pkg::*;

    // a stalled result item holds still
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=>
            result_valid && $stable({point_number, figure_number, contained, last}))
    else $error("result item changed while stalled");

    // a "none" result is the only result of its query
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !contained |-> figure_number == '0 && last)
    else $error("none result without zero figure or last");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && contained |-> figure_number != '0)
    else $error("contained result names no figure");

    // a query keeps the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && action == ACT_QUERY |=> !item_ready)
    else $error("input ready straight after a query item");

    // a clear item does not make the input side busy
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && action == ACT_CLEAR |=> item_ready)
    else $error("input not ready after a clear item");

endmodule

bind point_in_shapes_tester_core pst_checker u_pst_checker (.*);
